### rtl/core/clp_pkg.sv
// Shared types, codes and helper functions for the four-channel credit link port.
// Used by the channel interfaces and every module under rtl/core but clp_ram.
`default_nettype none

package clp_pkg;

	localparam int NUM_CH          = 4;
	localparam int CH_W            = 2;
	localparam int CRED_W          = 8;
	localparam int PAYLOAD_W       = 64;
	localparam int OCC_W           = 5;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;
	localparam int RX_DEPTH_DFLT   = 16;
	localparam int FLIT_WIDTH_DFLT = 64;

	localparam logic [CRED_W-1:0] PEER_DEPTH_RST = 8'd16;

	// Register index as decoded from paddr[2].
	localparam logic REG_PEER_DEPTH = 1'b0;

	typedef enum logic [1:0] {
		KIND_SEND  = 2'd0,
		KIND_GRANT = 2'd1,
		KIND_FLIT  = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RK_SEND    = 3'd0,
		RK_GRANT   = 3'd1,
		RK_RECV    = 3'd2,
		RK_DELIVER = 3'd3,
		RK_IDLE    = 3'd4
	} rkind_t;

	localparam logic [CH_W-1:0] CH_REQ  = 2'd0;
	localparam logic [CH_W-1:0] CH_SNP  = 2'd1;
	localparam logic [CH_W-1:0] CH_DAT  = 2'd2;
	localparam logic [CH_W-1:0] CH_RSP  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DELIVER
	} clp_state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [CH_W-1:0]       channel;
		logic [PAYLOAD_W-1:0]  payload;
		logic [NUM_CH-1:0]     accept_mask;
	} clp_in_t;

	typedef struct packed {
		rkind_t                result_kind;
		logic [CH_W-1:0]       result_channel;
		logic                  ok;
		logic                  blocked_by_credit;
		logic                  unblocked;
		logic [CRED_W-1:0]     credits_left;
		logic [PAYLOAD_W-1:0]  flit_out;
		logic [OCC_W-1:0]      occupancy;
		logic                  overflow;
		logic                  last;
	} clp_out_t;

	typedef struct packed {
		logic            send;
		logic            grant;
		logic            tick;
		logic [CH_W-1:0] ch;
	} tx_op_t;

	typedef struct packed {
		logic              ok;
		logic              blocked;
		logic              unblocked;
		logic [CRED_W-1:0] credits;
	} tx_stat_t;

	typedef struct packed {
		logic            store;
		logic            rd;
		logic            pop;
		logic [CH_W-1:0] ch;
	} rx_ctl_t;

	typedef struct packed {
		logic              stored;
		logic              overflow;
		logic [NUM_CH-1:0] busy;
	} rx_stat_t;

	// Service order on a tick: snoop, response, data, request.
	function automatic logic [CH_W-1:0] serve_pick(input logic [NUM_CH-1:0] pend);
		logic [CH_W-1:0] pick;
		pick = CH_REQ;
		priority if (pend[CH_SNP]) pick = CH_SNP;
		else if (pend[CH_RSP])     pick = CH_RSP;
		else if (pend[CH_DAT])     pick = CH_DAT;
		else                       pick = CH_REQ;
		return pick;
	endfunction

endpackage

`default_nettype wire

### rtl/core/clp_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on clp_pkg for the payload structs.
`default_nettype none

interface clp_in_if;
	logic              valid;
	logic              ready;
	clp_pkg::clp_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface clp_out_if;
	logic              valid;
	logic              ready;
	clp_pkg::clp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/four_channel_credit_link_port.sv
// Top level of the four-channel credit link port: sequencer, output register and
// APB register. Depends on clp_pkg, clp_ifs, clp_tx_credit and clp_rx_queue.
`default_nettype none

// Credit-based link port for four channels (request, snoop, data, response).
// Items enter on cmd and results leave on res, both valid/ready; one item is
// worked on at a time, and the next item is taken as soon as the sequencer is
// back in idle, even if the last result still sits in the output register.
// A send, a credit grant or an incoming flit is captured, then executed, and
// gives one result. A tick is captured and executed; each non-empty receive
// queue then has its head read from the shared flit RAM (registered read port)
// in ST_READ and delivered in ST_DELIVER. A tick that finds all queues empty
// gives a single idle result. Results also wait whenever res is stalled.
// The peer_buffer_depth register sits at byte address 0 of the APB port; a write
// loads every transmit credit counter with the new depth and should happen only
// while the port is idle. The flit RAM needs no clearing pass after reset, since
// an entry is only read after it has been written.
module four_channel_credit_link_port #(
	parameter int RX_DEPTH   = clp_pkg::RX_DEPTH_DFLT,
	parameter int FLIT_WIDTH = clp_pkg::FLIT_WIDTH_DFLT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	clp_in_if.sink                             cmd,
	clp_out_if.source                          res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [clp_pkg::APB_AW-1:0]    paddr,
	input  wire logic [clp_pkg::APB_DW-1:0]    pwdata,
	output logic      [clp_pkg::APB_DW-1:0]    prdata,
	output logic                               pready
);
	import clp_pkg::*;

	localparam int CNT_W = $clog2(RX_DEPTH + 1);

	// Sequencer state and the captured item.
	clp_state_t        state_q;
	clp_state_t        state_d;
	clp_in_t           cmd_q;
	logic [NUM_CH-1:0] pend_q;
	logic [NUM_CH-1:0] pend_d;

	// Output register.
	logic     res_vld_q;
	clp_out_t res_q;
	clp_out_t res_d;
	logic     emit;
	logic     out_free;

	// Configuration register.
	logic [CRED_W-1:0] depth_q;
	logic              cfg_wr;

	// Sub-block control and status.
	tx_op_t            tx_op;
	tx_stat_t          tx_stat;
	rx_ctl_t           rx_ctl;
	rx_stat_t          rx_stat;
	logic [CNT_W-1:0]  rx_count;
	logic [FLIT_WIDTH-1:0] head_data;

	logic [CH_W-1:0]   q_sel;
	logic [NUM_CH-1:0] rest;
	logic              take;

	// APB: one register, always ready, writes complete in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PEER_DEPTH);

	always_comb begin
		if (paddr[2] == REG_PEER_DEPTH) begin
			prdata = APB_DW'(depth_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= PEER_DEPTH_RST;
		end else if (cfg_wr) begin
			depth_q <= pwdata[CRED_W-1:0];
		end
	end

	// The result register may load whenever it is empty or being emptied.
	assign out_free  = !res_vld_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	// Next queue to serve on a tick, and the set left after it.
	assign q_sel = serve_pick(pend_q);
	assign rest  = pend_q & ~(NUM_CH'(1) << q_sel);
	assign take  = cmd_q.accept_mask[q_sel];

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		emit    = 1'b0;
		tx_op   = '0;
		rx_ctl  = '0;

		res_d                   = '0;
		res_d.blocked_by_credit = tx_stat.blocked;
		res_d.credits_left      = tx_stat.credits;
		res_d.occupancy         = OCC_W'(rx_count);
		res_d.last              = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				tx_op.ch             = cmd_q.channel;
				rx_ctl.ch            = cmd_q.channel;
				res_d.result_channel = cmd_q.channel;
				unique case (cmd_q.kind)
					KIND_SEND: begin
						if (out_free) begin
							tx_op.send        = 1'b1;
							emit              = 1'b1;
							res_d.result_kind = RK_SEND;
							res_d.ok          = tx_stat.ok;
							res_d.flit_out    = tx_stat.ok ?
								PAYLOAD_W'(cmd_q.payload[FLIT_WIDTH-1:0]) : '0;
							state_d           = ST_IDLE;
						end
					end
					KIND_GRANT: begin
						if (out_free) begin
							tx_op.grant       = 1'b1;
							emit              = 1'b1;
							res_d.result_kind = RK_GRANT;
							res_d.ok          = 1'b1;
							res_d.unblocked   = tx_stat.unblocked;
							state_d           = ST_IDLE;
						end
					end
					KIND_FLIT: begin
						if (out_free) begin
							rx_ctl.store      = 1'b1;
							emit              = 1'b1;
							res_d.result_kind = RK_RECV;
							res_d.ok          = rx_stat.stored;
							res_d.overflow    = rx_stat.overflow;
							state_d           = ST_IDLE;
						end
					end
					KIND_TICK: begin
						// The idle result reports channel 0.
						tx_op.ch             = CH_REQ;
						rx_ctl.ch            = CH_REQ;
						res_d.result_channel = CH_REQ;
						if (rx_stat.busy == '0) begin
							if (out_free) begin
								tx_op.tick        = 1'b1;
								emit              = 1'b1;
								res_d.result_kind = RK_IDLE;
								state_d           = ST_IDLE;
							end
						end else begin
							// Snapshot of busy queues taken before any pop.
							tx_op.tick = 1'b1;
							pend_d     = rx_stat.busy;
							state_d    = ST_READ;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_READ: begin
				// Head read; the data comes back from the RAM next cycle.
				rx_ctl.rd = 1'b1;
				rx_ctl.ch = q_sel;
				tx_op.ch  = q_sel;
				state_d   = ST_DELIVER;
			end
			ST_DELIVER: begin
				tx_op.ch             = q_sel;
				rx_ctl.ch            = q_sel;
				res_d.result_channel = q_sel;
				if (out_free) begin
					rx_ctl.pop        = take;
					emit              = 1'b1;
					res_d.result_kind = RK_DELIVER;
					res_d.ok          = take;
					res_d.flit_out    = PAYLOAD_W'(head_data);
					res_d.last        = (rest == '0);
					pend_d            = rest;
					state_d           = (rest == '0) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			pend_q <= pend_d;
			if (emit) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.data;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	clp_tx_credit u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_load  (cfg_wr),
		.cfg_depth (pwdata[CRED_W-1:0]),
		.op        (tx_op),
		.stat      (tx_stat)
	);

	clp_rx_queue #(
		.RX_DEPTH   (RX_DEPTH),
		.FLIT_WIDTH (FLIT_WIDTH)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (rx_ctl),
		.wdata       (cmd_q.payload[FLIT_WIDTH-1:0]),
		.stat        (rx_stat),
		.count_after (rx_count),
		.head_data   (head_data)
	);

`ifndef SYNTHESIS
	a_read_then_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_DELIVER))
		else $error("head read not followed by its delivery");

	a_pend_in_service: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_READ) || (state_q == ST_DELIVER)) |-> (pend_q != '0))
		else $error("tick service running with no queue pending");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pend_q == '0))
		else $error("pending service left over when back in idle");
`endif

endmodule

`default_nettype wire

### rtl/core/clp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module clp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/core/clp_tx_credit.sv
// Transmit side: per-channel credit counters, send-once-per-tick flags and
// credit block flags. Depends on clp_pkg.
`default_nettype none

module clp_tx_credit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_load,
	input  wire logic [clp_pkg::CRED_W-1:0]   cfg_depth,
	input  wire clp_pkg::tx_op_t              op,
	output clp_pkg::tx_stat_t                 stat
);
	import clp_pkg::*;

	logic [CRED_W-1:0] cred_q [NUM_CH];
	logic [NUM_CH-1:0] sent_q;
	logic [NUM_CH-1:0] blk_q;

	logic [CRED_W-1:0] cur;
	logic [CRED_W-1:0] cred_nxt;
	logic              blk_nxt;
	logic              sent_nxt;
	logic              ok;
	logic              unblk;

	// Post-step values for the addressed channel; the result shows these.
	always_comb begin
		cur      = cred_q[op.ch];
		cred_nxt = cur;
		blk_nxt  = blk_q[op.ch];
		sent_nxt = sent_q[op.ch];
		ok       = 1'b0;
		unblk    = 1'b0;
		if (op.send) begin
			if (cur == '0) begin
				blk_nxt = 1'b1;
			end else if (!sent_q[op.ch]) begin
				blk_nxt  = 1'b0;
				cred_nxt = cur - 1'b1;
				sent_nxt = 1'b1;
				ok       = 1'b1;
			end
		end else if (op.grant) begin
			if (cur != '1) begin
				cred_nxt = cur + 1'b1;
			end
			// A channel that just got its first credit waits for the next tick.
			if (cred_nxt == CRED_W'(1)) begin
				sent_nxt = 1'b1;
			end
			if (blk_q[op.ch]) begin
				blk_nxt = 1'b0;
				unblk   = 1'b1;
			end
		end
	end

	assign stat.ok        = ok;
	assign stat.blocked   = blk_nxt;
	assign stat.unblocked = unblk;
	assign stat.credits   = cred_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				cred_q[i] <= PEER_DEPTH_RST;
			end
			sent_q <= '1;
			blk_q  <= '0;
		end else if (cfg_load) begin
			for (int i = 0; i < NUM_CH; i++) begin
				cred_q[i] <= cfg_depth;
			end
		end else begin
			if (op.send || op.grant) begin
				cred_q[op.ch] <= cred_nxt;
				blk_q[op.ch]  <= blk_nxt;
				sent_q[op.ch] <= sent_nxt;
			end
			if (op.tick) begin
				sent_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/clp_rx_queue.sv
// Receive side: four circular queues sharing one flit RAM, with per-channel
// head pointers and fill counts. Depends on clp_pkg and clp_ram.
`default_nettype none

module clp_rx_queue #(
	parameter int RX_DEPTH   = clp_pkg::RX_DEPTH_DFLT,
	parameter int FLIT_WIDTH = clp_pkg::FLIT_WIDTH_DFLT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire clp_pkg::rx_ctl_t                  ctl,
	input  wire logic [FLIT_WIDTH-1:0]             wdata,
	output clp_pkg::rx_stat_t                      stat,
	output logic      [$clog2(RX_DEPTH+1)-1:0]     count_after,
	output logic      [FLIT_WIDTH-1:0]             head_data
);
	import clp_pkg::*;

	localparam int PTR_W     = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CNT_W     = $clog2(RX_DEPTH + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int MEM_DEPTH = NUM_CH * RX_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	logic [PTR_W-1:0] head_q [NUM_CH];
	logic [CNT_W-1:0] cnt_q  [NUM_CH];

	logic [PTR_W-1:0]  head;
	logic [PTR_W-1:0]  head_inc;
	logic [CNT_W-1:0]  cnt;
	logic              full;
	logic              stored;
	logic [SUM_W-1:0]  wsum;
	logic [SUM_W-1:0]  wpos;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	always_comb begin
		head   = head_q[ctl.ch];
		cnt    = cnt_q[ctl.ch];
		full   = (cnt == CNT_W'(RX_DEPTH));
		stored = ctl.store && !full;
		// Tail slot: head + count wraps at most once, so one subtract does it.
		wsum   = SUM_W'(head) + SUM_W'(cnt);
		wpos   = (wsum >= SUM_W'(RX_DEPTH)) ? (wsum - SUM_W'(RX_DEPTH)) : wsum;
		base   = ADDR_W'(ctl.ch) * ADDR_W'(RX_DEPTH);
		waddr  = base + ADDR_W'(wpos);
		raddr  = base + ADDR_W'(head);
		head_inc = (head == PTR_W'(RX_DEPTH - 1)) ? '0 : (head + 1'b1);
		if (stored) begin
			count_after = cnt + 1'b1;
		end else if (ctl.pop) begin
			count_after = cnt - 1'b1;
		end else begin
			count_after = cnt;
		end
		for (int i = 0; i < NUM_CH; i++) begin
			stat.busy[i] = (cnt_q[i] != '0);
		end
		stat.stored   = stored;
		stat.overflow = ctl.store && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (stored) begin
				cnt_q[ctl.ch] <= cnt + 1'b1;
			end else if (ctl.pop) begin
				cnt_q[ctl.ch]  <= cnt - 1'b1;
				head_q[ctl.ch] <= head_inc;
			end
		end
	end

	clp_ram #(
		.WIDTH (FLIT_WIDTH),
		.DEPTH (MEM_DEPTH)
	) u_flit_ram (
		.clk   (clk),
		.we    (stored),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.rd),
		.raddr (raddr),
		.rdata (head_data)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CNT_W'(RX_DEPTH)) && (cnt_q[1] <= CNT_W'(RX_DEPTH)) &&
		(cnt_q[2] <= CNT_W'(RX_DEPTH)) && (cnt_q[3] <= CNT_W'(RX_DEPTH)))
		else $error("receive queue count above its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (cnt != '0))
		else $error("pop issued on an empty receive queue");
`endif

endmodule

`default_nettype wire

### tb/four_channel_credit_link_port_test.sv
// Self-checking testbench for the four-channel credit link port: directed and random
// items on the cmd channel, results checked on res against a cycle-free predictor.
// Depends on clp_pkg, clp_ifs and the four_channel_credit_link_port RTL.
`timescale 1ns / 1ps

module four_channel_credit_link_port_test;
	import clp_pkg::*;

	localparam int RX_SLOTS    = RX_DEPTH_DFLT;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	// Order in which a tick serves the receive queues.
	localparam logic [CH_W-1:0] SERVE_ORDER [NUM_CH] = '{CH_SNP, CH_RSP, CH_DAT, CH_REQ};

	// Register index that decodes to nothing; writes to it must leave the port alone.
	localparam logic REG_UNMAPPED = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	clp_in_if  cmd_if ();
	clp_out_if res_if ();

	four_channel_credit_link_port dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items waiting to be offered, and results the port still owes us.
	clp_in_t  link_items_pending [$];
	clp_out_t link_results_due [$];

	// Knobs that the stimulus process changes between phases, always at a falling edge
	// so that the clocked processes never see them change within their own time step.
	int unsigned sender_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	logic        pressure_req = 1'b0;

	int unsigned mismatch_count = 0;
	int unsigned run_cycles = 0;

	// Shadow of the port's state, kept in step with every accepted item.
	logic [CRED_W-1:0]    credit_cnt     [NUM_CH];
	logic                 send_used      [NUM_CH];
	logic                 credit_blocked [NUM_CH];
	logic [PAYLOAD_W-1:0] rx_fifo        [NUM_CH][RX_SLOTS];
	logic [3:0]           rx_rd          [NUM_CH];
	logic [OCC_W-1:0]     rx_fill        [NUM_CH];

	// A result carries the channel's state as it stands after the step.
	function automatic clp_out_t link_result(rkind_t rk, logic [CH_W-1:0] ch, logic ok,
			logic unblk, logic [PAYLOAD_W-1:0] flit, logic ovf, logic is_last);
		clp_out_t r;
		r.result_kind       = rk;
		r.result_channel    = ch;
		r.ok                = ok;
		r.blocked_by_credit = credit_blocked[ch];
		r.unblocked         = unblk;
		r.credits_left      = credit_cnt[ch];
		r.flit_out          = flit;
		r.occupancy         = rx_fill[ch];
		r.overflow          = ovf;
		r.last              = is_last;
		return r;
	endfunction

	// Advances the shadow state by one item and queues the results it must cause.
	function automatic void predict_link_step(clp_in_t it);
		logic [CH_W-1:0] ch;
		logic [CH_W-1:0] q;
		logic [3:0]      wr_pos;
		logic            fwd;
		logic            prior_blk;
		logic            unblk;
		logic            take;
		int              busy;
		int              seen;
		ch = it.channel;
		fwd = 1'b0;
		unblk = 1'b0;
		busy = 0;
		seen = 0;
		case (it.kind)
			KIND_SEND: begin
				// No credit blocks the channel; a second send before the next tick is just refused.
				if (credit_cnt[ch] == '0) begin
					credit_blocked[ch] = 1'b1;
				end else if (!send_used[ch]) begin
					credit_blocked[ch] = 1'b0;
					credit_cnt[ch] = credit_cnt[ch] - 1'b1;
					send_used[ch] = 1'b1;
					fwd = 1'b1;
				end
				link_results_due.push_back(link_result(RK_SEND, ch, fwd, 1'b0,
					fwd ? it.payload : '0, 1'b0, 1'b1));
			end
			KIND_GRANT: begin
				prior_blk = credit_blocked[ch];
				if (credit_cnt[ch] != 8'hFF)
					credit_cnt[ch] = credit_cnt[ch] + 1'b1;
				// Coming back from zero credits holds sending until the next tick.
				if (credit_cnt[ch] == 8'd1)
					send_used[ch] = 1'b1;
				if (prior_blk && credit_cnt[ch] != '0) begin
					credit_blocked[ch] = 1'b0;
					unblk = 1'b1;
				end
				link_results_due.push_back(link_result(RK_GRANT, ch, 1'b1, unblk, '0,
					1'b0, 1'b1));
			end
			KIND_FLIT: begin
				if (rx_fill[ch] < RX_SLOTS) begin
					wr_pos = rx_rd[ch] + rx_fill[ch][3:0];
					rx_fifo[ch][wr_pos] = it.payload;
					rx_fill[ch] = rx_fill[ch] + 1'b1;
					fwd = 1'b1;
				end
				link_results_due.push_back(link_result(RK_RECV, ch, fwd, 1'b0, '0, !fwd,
					1'b1));
			end
			KIND_TICK: begin
				for (int c = 0; c < NUM_CH; c++) begin
					send_used[c] = 1'b0;
					if (rx_fill[c] != '0)
						busy++;
				end
				if (busy == 0) begin
					link_results_due.push_back(link_result(RK_IDLE, CH_REQ, 1'b0, 1'b0, '0,
						1'b0, 1'b1));
				end else begin
					for (int i = 0; i < NUM_CH; i++) begin
						q = SERVE_ORDER[i];
						if (rx_fill[q] != '0) begin
							seen++;
							take = it.accept_mask[q];
							// The head is reported whether or not the consumer takes it.
							link_results_due.push_back(link_result(RK_DELIVER, q, take, 1'b0,
								rx_fifo[q][rx_rd[q]], 1'b0, seen == busy));
							if (take) begin
								rx_rd[q] = rx_rd[q] + 1'b1;
								rx_fill[q] = rx_fill[q] - 1'b1;
							end
							if (take) begin
								// Occupancy in the result is taken after the pop.
								link_results_due[$].occupancy = rx_fill[q];
							end
						end
					end
				end
			end
		endcase
	endfunction

	function automatic logic [PAYLOAD_W-1:0] flit_pattern();
		logic [PAYLOAD_W-1:0] p;
		case ($urandom_range(7))
			0: p = '1;
			1: p = '0;
			default: p = {$urandom, $urandom};
		endcase
		return p;
	endfunction

	task automatic push_item(kind_t k, logic [CH_W-1:0] ch, logic [PAYLOAD_W-1:0] pl,
			logic [NUM_CH-1:0] mask);
		clp_in_t it;
		it.kind = k;
		it.channel = ch;
		it.payload = pl;
		it.accept_mask = mask;
		link_items_pending.push_back(it);
	endtask

	// Random traffic. Most of it is ordinary link activity: ticks that open a cycle,
	// sends that spend credit, grants that return it and flits that fill the queues.
	// Now and then a burst of flits to one channel drives a queue toward full.
	task automatic push_random_traffic(int n);
		int          added;
		int          r;
		int          burst;
		logic [CH_W-1:0] ch;
		logic [NUM_CH-1:0] mask;
		added = 0;
		while (added < n) begin
			r = $urandom_range(99);
			ch = CH_W'($urandom_range(3));
			if (r < 6) begin
				burst = $urandom_range(4, 10);
				for (int i = 0; i < burst; i++)
					push_item(KIND_FLIT, ch, flit_pattern(), '0);
				added += burst;
			end else begin
				mask = ($urandom_range(2) == 0) ? 4'hF : 4'($urandom);
				if (r < 33)
					push_item(KIND_SEND, ch, flit_pattern(), 4'($urandom));
				else if (r < 52)
					push_item(KIND_GRANT, ch, flit_pattern(), 4'($urandom));
				else if (r < 76)
					push_item(KIND_FLIT, ch, flit_pattern(), 4'($urandom));
				else
					push_item(KIND_TICK, ch, flit_pattern(), mask);
				added++;
			end
		end
	endtask

	// Waits until every item is in and every result is out, then lets the clock run on
	// so that the sequencer falls back to idle before the register is touched.
	task automatic drain_link();
		while (link_items_pending.size() != 0 || link_results_due.size() != 0 ||
				cmd_if.valid)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value at the
	// edge that closes the access cycle. Bits above the depth are filled with noise.
	task automatic write_peer_depth(logic reg_idx, logic [CRED_W-1:0] depth);
		logic [APB_DW-CRED_W-1:0] noise;
		noise = (APB_DW-CRED_W)'($urandom);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {noise, depth};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_PEER_DEPTH) begin
			for (int c = 0; c < NUM_CH; c++)
				credit_cnt[c] = depth;
		end
		@(negedge clk);
	endtask

	task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
		sender_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// Driver: offers the next pending item, holds it until taken, and feeds every
	// accepted item to the predictor at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.data <= '0;
		end else begin
			if (cmd_if.valid && cmd_if.ready)
				predict_link_step(cmd_if.data);
			if (!cmd_if.valid || cmd_if.ready) begin
				if (link_items_pending.size() != 0 &&
						$urandom_range(99) >= sender_idle_pct) begin
					cmd_if.valid <= 1'b1;
					cmd_if.data <= link_items_pending.pop_front();
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [PAYLOAD_W-1:0] want,
			logic [PAYLOAD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Long receiver hold-off: once asked for, res.ready is held low while hold_count
	// runs up, so that the output register fills and cmd stops accepting.
	logic        hold_off;
	int unsigned hold_count;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
			hold_count <= 0;
		end else if (hold_off) begin
			if (hold_count == HOLD_CYCLES - 1)
				hold_off <= 1'b0;
			hold_count <= hold_count + 1;
		end else if (pressure_req && hold_count == 0) begin
			hold_off <= 1'b1;
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		clp_out_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (link_results_due.size() == 0) begin
					$error("result with nothing expected: kind %0d channel %0d",
						res_if.data.result_kind, res_if.data.result_channel);
					mismatch_count++;
				end else begin
					want = link_results_due.pop_front();
					check_field("result_kind", PAYLOAD_W'(want.result_kind),
						PAYLOAD_W'(res_if.data.result_kind));
					check_field("result_channel", PAYLOAD_W'(want.result_channel),
						PAYLOAD_W'(res_if.data.result_channel));
					check_field("ok", PAYLOAD_W'(want.ok), PAYLOAD_W'(res_if.data.ok));
					check_field("blocked_by_credit", PAYLOAD_W'(want.blocked_by_credit),
						PAYLOAD_W'(res_if.data.blocked_by_credit));
					check_field("unblocked", PAYLOAD_W'(want.unblocked),
						PAYLOAD_W'(res_if.data.unblocked));
					check_field("credits_left", PAYLOAD_W'(want.credits_left),
						PAYLOAD_W'(res_if.data.credits_left));
					check_field("flit_out", want.flit_out, res_if.data.flit_out);
					check_field("occupancy", PAYLOAD_W'(want.occupancy),
						PAYLOAD_W'(res_if.data.occupancy));
					check_field("overflow", PAYLOAD_W'(want.overflow),
						PAYLOAD_W'(res_if.data.overflow));
					check_field("last", PAYLOAD_W'(want.last), PAYLOAD_W'(res_if.data.last));
				end
			end
			res_if.ready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog against a hung port.
	always @(posedge clk) begin
		run_cycles++;
		if (run_cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [CH_W-1:0] burst_ch;

		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		res_if.ready = 1'b0;

		// Shadow state as it comes out of reset: no sending before the first tick.
		for (int c = 0; c < NUM_CH; c++) begin
			credit_cnt[c] = PEER_DEPTH_RST;
			send_used[c] = 1'b1;
			credit_blocked[c] = 1'b0;
			rx_rd[c] = '0;
			rx_fill[c] = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset depth, no idling on either side.
		set_idling(0, 0);
		// A send before the first tick is refused without blocking the channel.
		push_item(KIND_SEND, CH_REQ, '1, '0);
		// All queues empty: a single idle result.
		push_item(KIND_TICK, CH_RSP, '0, '0);
		push_item(KIND_SEND, CH_REQ, '1, '0);
		// Second send on the same channel before the next tick.
		push_item(KIND_SEND, CH_REQ, '1, '0);
		push_item(KIND_SEND, CH_SNP, '0, '1);
		push_item(KIND_SEND, CH_DAT, 64'h5555_5555_5555_5555, '0);
		push_item(KIND_SEND, CH_RSP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		push_item(KIND_FLIT, CH_REQ, '1, '0);
		push_item(KIND_FLIT, CH_SNP, '0, '0);
		push_item(KIND_FLIT, CH_DAT, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		push_item(KIND_FLIT, CH_RSP, 64'h5555_5555_5555_5555, '1);
		// Four deliveries nobody accepts, then the same four taken.
		push_item(KIND_TICK, CH_REQ, '0, 4'h0);
		push_item(KIND_TICK, CH_DAT, '1, 4'hF);
		push_item(KIND_TICK, CH_SNP, '0, 4'hA);
		push_item(KIND_GRANT, CH_REQ, '0, '0);
		push_item(KIND_GRANT, CH_RSP, '1, '0);
		drain_link();

		// Smallest depth: one credit per channel, so the credit block is reached fast.
		write_peer_depth(REG_PEER_DEPTH, 8'd1);
		push_item(KIND_TICK, CH_REQ, '0, 4'hF);
		push_item(KIND_SEND, CH_DAT, 64'h0123_4567_89AB_CDEF, '0);
		push_item(KIND_TICK, CH_REQ, '0, 4'hF);
		// Out of credit: the channel blocks.
		push_item(KIND_SEND, CH_DAT, 64'hFEDC_BA98_7654_3210, '0);
		// The grant lifts the block but holds sending until the next tick.
		push_item(KIND_GRANT, CH_DAT, '0, '0);
		push_item(KIND_SEND, CH_DAT, 64'hFEDC_BA98_7654_3210, '0);
		push_item(KIND_TICK, CH_REQ, '0, 4'hF);
		push_item(KIND_SEND, CH_DAT, 64'hFEDC_BA98_7654_3210, '0);
		drain_link();

		// Largest depth: a grant on a full credit counter saturates.
		write_peer_depth(REG_PEER_DEPTH, 8'hFF);
		push_item(KIND_GRANT, CH_RSP, '0, '0);
		push_item(KIND_TICK, CH_REQ, '0, 4'hF);
		push_item(KIND_SEND, CH_RSP, '1, '0);
		drain_link();

		// A write to an address with no register must change nothing.
		write_peer_depth(REG_UNMAPPED, 8'($urandom));

		// Random phases, each with its own depth and idling pattern.
		write_peer_depth(REG_PEER_DEPTH, PEER_DEPTH_RST);
		set_idling(0, 0);
		push_random_traffic(14);
		drain_link();

		write_peer_depth(REG_PEER_DEPTH, 8'd2);
		set_idling(69, 0);
		push_random_traffic(14);
		drain_link();

		write_peer_depth(REG_PEER_DEPTH, 8'($urandom_range(3, 254)));
		set_idling(0, 69);
		push_random_traffic(14);
		drain_link();

		write_peer_depth(REG_PEER_DEPTH, 8'hFF);
		set_idling(26, 26);
		push_random_traffic(14);
		drain_link();

		// Back pressure: the receiver holds off while the sender keeps offering a
		// burst that overruns one queue, followed by ticks that each take its head.
		write_peer_depth(REG_PEER_DEPTH, 8'd1);
		set_idling(0, 0);
		burst_ch = CH_W'($urandom_range(3));
		pressure_req = 1'b1;
		for (int i = 0; i < RX_SLOTS + 3; i++)
			push_item(KIND_FLIT, burst_ch, flit_pattern(), '0);
		for (int i = 0; i < 4; i++)
			push_item(KIND_TICK, CH_REQ, '0, 4'($urandom) | 4'(1 << burst_ch));
		push_random_traffic(6);
		drain_link();
		pressure_req = 1'b0;

		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && link_results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
